// File: rtl/grp_pkg.sv
// Package with character codes and the structs shared by the genotype record parser.
package grp_pkg;

	// Character codes that steer the parser.
	localparam logic [7:0] ChNul  = 8'h00;
	localparam logic [7:0] ChHash = 8'h23;
	localparam logic [7:0] ChR    = 8'h72;
	localparam logic [7:0] ChM    = 8'h4D;
	localparam logic [7:0] ChSp   = 8'h20;
	localparam logic [7:0] ChTab  = 8'h09;
	localparam logic [7:0] ChCr   = 8'h0D;
	localparam logic [7:0] ChLf   = 8'h0A;
	localparam logic [7:0] Ch0    = 8'h30;
	localparam logic [7:0] Ch9    = 8'h39;

	localparam int IdWidth = 32;

	// Saturation limits of the field and character counters.
	localparam logic [2:0] FieldMax = 3'd4;
	localparam logic [1:0] PosMax   = 2'd3;

	// Field numbers of a record.
	localparam logic [2:0] FieldId    = 3'd0;
	localparam logic [2:0] FieldChrom = 3'd1;
	localparam logic [2:0] FieldGeno  = 3'd3;

	// Contents of the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} stage_t;

	// One finished record as handed to the output register.
	typedef struct packed {
		logic               emit;
		logic [IdWidth-1:0] snp_id;
		logic [7:0]         allele_one;
		logic [7:0]         allele_two;
	} result_t;

endpackage

// File: rtl/grp_if.sv
// Interfaces for the byte request channel and the record request channel.
interface grp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface grp_rec_if;
	logic                       valid;
	logic                       ready;
	logic [grp_pkg::IdWidth-1:0] snp_id;
	logic [7:0]                 allele_one;
	logic [7:0]                 allele_two;

	modport source (output valid, output snp_id, output allele_one, output allele_two,
		input ready);
	modport sink (input valid, input snp_id, input allele_one, input allele_two,
		output ready);
endinterface

// File: rtl/grp_in_stage.sv
// Input register that holds one byte request until the parser takes it.
module grp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	grp_byte_if.sink          stream,
	input  logic              advance,
	output grp_pkg::stage_t   s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// A new request may enter when the register is empty or drains this cycle.
	assign stream.ready = !valid_s1 || advance;

	// Valid bit of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Byte payload; it needs no reset.
	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.byte_in;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.data  = byte_s1;

endmodule

// File: rtl/grp_parse_core.sv
// Parser state and the per-byte next-state logic that ends records.
module grp_parse_core (
	input  logic              clk,
	input  logic              arst_n,
	input  grp_pkg::stage_t   s1,
	input  logic              advance,
	output grp_pkg::result_t  res
);

	logic                        in_header_q, in_comment_q, at_line_start_q, after_cr_q;
	logic [2:0]                  field_number_q;
	logic [1:0]                  char_position_q;
	logic                        id_has_prefix_q, digits_done_q, mito_flag_q;
	logic [grp_pkg::IdWidth-1:0] id_accumulator_q;
	logic [7:0]                  first_allele_q, second_allele_q;

	logic                        in_header_d, in_comment_d, at_line_start_d, after_cr_d;
	logic [2:0]                  field_number_d;
	logic [1:0]                  char_position_d;
	logic                        id_has_prefix_d, digits_done_d, mito_flag_d;
	logic [grp_pkg::IdWidth-1:0] id_accumulator_d;
	logic [7:0]                  first_allele_d, second_allele_d;

	logic                        fire;
	logic                        finish;
	logic [7:0]                  c;
	logic [grp_pkg::IdWidth+3:0] times_ten;
	logic                        is_digit;

	assign fire = s1.valid && advance;
	assign c    = s1.data;

	// Accumulator times ten plus the digit, with four guard bits for saturation.
	assign is_digit  = (c >= grp_pkg::Ch0) && (c <= grp_pkg::Ch9);
	assign times_ten = {1'b0, id_accumulator_q, 3'b000} + {3'b000, id_accumulator_q, 1'b0}
		+ {{(grp_pkg::IdWidth){1'b0}}, c[3:0] - grp_pkg::Ch0[3:0]};

	// Next state for the byte in the input register.
	always_comb begin
		in_header_d      = in_header_q;
		in_comment_d     = in_comment_q;
		at_line_start_d  = at_line_start_q;
		after_cr_d       = 1'b0;
		field_number_d   = field_number_q;
		char_position_d  = char_position_q;
		id_has_prefix_d  = id_has_prefix_q;
		digits_done_d    = digits_done_q;
		id_accumulator_d = id_accumulator_q;
		mito_flag_d      = mito_flag_q;
		first_allele_d   = first_allele_q;
		second_allele_d  = second_allele_q;
		finish           = 1'b0;

		if (c == grp_pkg::ChNul) begin
			finish = 1'b1;
		end else if (in_comment_q) begin
			// Header comment lines end only at LF.
			if (c == grp_pkg::ChLf) begin
				in_comment_d    = 1'b0;
				at_line_start_d = 1'b1;
			end
		end else if (in_header_q && at_line_start_q && c == grp_pkg::ChHash) begin
			in_comment_d    = 1'b1;
			at_line_start_d = 1'b0;
		end else begin
			in_header_d = 1'b0;
			if (c == grp_pkg::ChLf && after_cr_q) begin
				// The LF of a CRLF pair is absorbed.
			end else if (c == grp_pkg::ChCr || c == grp_pkg::ChLf) begin
				after_cr_d = (c == grp_pkg::ChCr);
				finish     = 1'b1;
			end else if (c == grp_pkg::ChTab) begin
				at_line_start_d = 1'b0;
				if (field_number_q < grp_pkg::FieldMax) begin
					field_number_d = field_number_q + 3'd1;
				end
				char_position_d = 2'd0;
			end else begin
				at_line_start_d = 1'b0;
				if (field_number_q == grp_pkg::FieldId) begin
					if (char_position_q == 2'd0) begin
						id_has_prefix_d = (c == grp_pkg::ChR);
					end else if (char_position_q >= 2'd2 && id_has_prefix_q && !digits_done_q)
					begin
						if (is_digit) begin
							id_accumulator_d = (times_ten[grp_pkg::IdWidth+3:grp_pkg::IdWidth] != 4'd0)
								? {(grp_pkg::IdWidth){1'b1}}
								: times_ten[grp_pkg::IdWidth-1:0];
						end else begin
							digits_done_d = 1'b1;
						end
					end
				end else if (field_number_q == grp_pkg::FieldChrom) begin
					if (char_position_q == 2'd0) begin
						mito_flag_d = (c == grp_pkg::ChM);
					end
				end else if (field_number_q == grp_pkg::FieldGeno) begin
					if (char_position_q == 2'd0) begin
						first_allele_d = c;
					end else if (char_position_q == 2'd1) begin
						second_allele_d = c;
					end
				end
				if (char_position_q < grp_pkg::PosMax) begin
					char_position_d = char_position_q + 2'd1;
				end
			end
		end

		// A finished record clears the per-record fields.
		if (finish) begin
			at_line_start_d  = 1'b1;
			field_number_d   = 3'd0;
			char_position_d  = 2'd0;
			id_has_prefix_d  = 1'b0;
			digits_done_d    = 1'b0;
			id_accumulator_d = '0;
			mito_flag_d      = 1'b0;
			first_allele_d   = grp_pkg::ChSp;
			second_allele_d  = grp_pkg::ChSp;
		end

		// A zero byte returns the parser to its state after reset.
		if (c == grp_pkg::ChNul) begin
			in_header_d  = 1'b1;
			in_comment_d = 1'b0;
			after_cr_d   = 1'b0;
		end
	end

	// Result of the record that this byte ends, if any.
	assign res.emit       = fire && finish && (id_accumulator_q != '0) && !mito_flag_q;
	assign res.snp_id     = id_accumulator_q;
	assign res.allele_one = first_allele_q;
	assign res.allele_two = second_allele_q;

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q      <= 1'b1;
			in_comment_q     <= 1'b0;
			at_line_start_q  <= 1'b1;
			after_cr_q       <= 1'b0;
			field_number_q   <= 3'd0;
			char_position_q  <= 2'd0;
			id_has_prefix_q  <= 1'b0;
			digits_done_q    <= 1'b0;
			id_accumulator_q <= '0;
			mito_flag_q      <= 1'b0;
			first_allele_q   <= grp_pkg::ChSp;
			second_allele_q  <= grp_pkg::ChSp;
		end else if (fire) begin
			in_header_q      <= in_header_d;
			in_comment_q     <= in_comment_d;
			at_line_start_q  <= at_line_start_d;
			after_cr_q       <= after_cr_d;
			field_number_q   <= field_number_d;
			char_position_q  <= char_position_d;
			id_has_prefix_q  <= id_has_prefix_d;
			digits_done_q    <= digits_done_d;
			id_accumulator_q <= id_accumulator_d;
			mito_flag_q      <= mito_flag_d;
			first_allele_q   <= first_allele_d;
			second_allele_q  <= second_allele_d;
		end
	end

endmodule

// File: rtl/grp_out_stage.sv
// Output register that holds one record request until the sink takes it.
module grp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  grp_pkg::result_t  res,
	output logic              stall,
	grp_rec_if.source         result
);

	logic                        valid_q;
	logic [grp_pkg::IdWidth-1:0] snp_id_q;
	logic [7:0]                  allele_one_q;
	logic [7:0]                  allele_two_q;

	// A waiting record that is not taken holds the parser.
	assign stall = valid_q && !result.ready;

	// Valid bit of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.emit) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Record payload; it needs no reset.
	always_ff @(posedge clk) begin
		if (res.emit) begin
			snp_id_q     <= res.snp_id;
			allele_one_q <= res.allele_one;
			allele_two_q <= res.allele_two;
		end
	end

	assign result.valid      = valid_q;
	assign result.snp_id     = snp_id_q;
	assign result.allele_one = allele_one_q;
	assign result.allele_two = allele_two_q;

endmodule

// File: rtl/genotype_record_parser.sv
// Top level of the genotype record parser: input register, parser, output register.
//
//   channel  | direction | payload                           | per request
//   ---------+-----------+-----------------------------------+-----------------------
//   stream   | in        | byte_in[7:0]                      | one file byte
//   result   | out       | snp_id[31:0], allele_one, allele_two | one finished record
//
// One byte is parsed per clock while the output register is not held by the sink;
// a byte request can then be taken in every cycle. The byte that ends a record
// passes the input register; the record then goes into the output register.
// The parser state advances only while the output register is not held by the sink.
// Reset (arst_n low) empties both registers and returns the parser to header mode.
module genotype_record_parser (
	input  logic      clk,
	input  logic      arst_n,
	grp_byte_if.sink  stream,
	grp_rec_if.source result
);

	grp_pkg::stage_t  s1;
	grp_pkg::result_t res;
	logic             stall;

	// Byte request register.
	grp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.advance (!stall),
		.s1      (s1)
	);

	// Parser state and record logic.
	grp_parse_core u_parse_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.advance (!stall),
		.res     (res)
	);

	// Record request register.
	grp_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.stall  (stall),
		.result (result)
	);

endmodule

// File: rtl/grp_checker.sv
// Port checker for the genotype record parser and its bind statement.
module grp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_snp_id,
	input logic [7:0]  out_allele_one,
	input logic [7:0]  out_allele_two
);

	// A record request stays up until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("record request dropped before it was taken");

	// A stalled record keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_snp_id) && $stable(out_allele_one)
			&& $stable(out_allele_two))
		else $error("record payload changed while stalled");

	// Records with a zero identifier are never sent.
	a_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_snp_id != 32'd0)
		else $error("record sent with zero identifier");

	// Bytes are taken whenever the result side is not held.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !out_ready) |-> in_ready)
		else $error("byte channel held while result side is free");

	// The byte channel stalls only while a record waits on the result side.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("byte channel stalled with no record waiting");

endmodule

bind genotype_record_parser grp_checker u_grp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (stream.valid),
	.in_ready       (stream.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_snp_id     (result.snp_id),
	.out_allele_one (result.allele_one),
	.out_allele_two (result.allele_two)
);

// File: tb/grp_record_checker.sv
// Checker that predicts the records of the genotype record parser and compares them.
`timescale 1ns / 100ps

module grp_record_checker
	import grp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	grp_byte_if  stream,
	grp_rec_if   result,
	output int   errors,
	output int   pending
);

	// One record as it should leave the block.
	typedef struct packed {
		logic [IdWidth-1:0] snp_id;
		logic [7:0]         allele_one;
		logic [7:0]         allele_two;
	} snp_rec_t;

	snp_rec_t expected_snps[$];
	snp_rec_t head_snp;
	int       mismatch_count = 0;
	int       open_snps = 0;

	// Parser state mirrored from the outside.
	logic               in_hdr;
	logic               in_cmt;
	logic               line_start;
	logic               saw_cr;
	logic [2:0]         field_idx;
	logic [1:0]         char_idx;
	logic               id_prefixed;
	logic               id_ended;
	logic [IdWidth-1:0] id_value;
	logic               mito;
	logic [7:0]         allele_a;
	logic [7:0]         allele_b;

	assign errors  = mismatch_count;
	assign pending = open_snps;

	function automatic void clear_record();
		line_start  = 1'b1;
		field_idx   = '0;
		char_idx    = '0;
		id_prefixed = 1'b0;
		id_ended    = 1'b0;
		id_value    = '0;
		mito        = 1'b0;
		allele_a    = ChSp;
		allele_b    = ChSp;
	endfunction

	function automatic void restart_parser();
		in_hdr = 1'b1;
		in_cmt = 1'b0;
		saw_cr = 1'b0;
		clear_record();
	endfunction

	// A record is kept only with a nonzero number and a chromosome other than M.
	function automatic void close_record();
		if (id_value != '0 && !mito) begin
			expected_snps.push_back('{id_value, allele_a, allele_b});
		end
		clear_record();
	endfunction

	// One ordinary character inside a field.
	function automatic void take_char(logic [7:0] c);
		logic [63:0] wide;
		line_start = 1'b0;
		if (field_idx == FieldId) begin
			if (char_idx == 2'd0) begin
				id_prefixed = (c == ChR);
			end else if (char_idx >= 2'd2 && id_prefixed && !id_ended) begin
				if (c >= Ch0 && c <= Ch9) begin
					wide = 64'(id_value) * 64'd10 + 64'(c - Ch0);
					id_value = (wide > 64'hFFFF_FFFF) ? '1 : wide[IdWidth-1:0];
				end else begin
					id_ended = 1'b1;
				end
			end
		end else if (field_idx == FieldChrom) begin
			if (char_idx == 2'd0) begin
				mito = (c == ChM);
			end
		end else if (field_idx == FieldGeno) begin
			if (char_idx == 2'd0) begin
				allele_a = c;
			end else if (char_idx == 2'd1) begin
				allele_b = c;
			end
		end
		if (char_idx < PosMax) begin
			char_idx++;
		end
	endfunction

	// Advances the mirrored parser by one accepted byte.
	function automatic void parse_byte(logic [7:0] c);
		logic was_cr;
		was_cr = saw_cr;
		saw_cr = 1'b0;
		if (c == ChNul) begin
			close_record();
			restart_parser();
			return;
		end
		// Header comments run up to LF only.
		if (in_cmt) begin
			if (c == ChLf) begin
				in_cmt     = 1'b0;
				line_start = 1'b1;
			end
			return;
		end
		if (in_hdr) begin
			if (line_start && c == ChHash) begin
				in_cmt     = 1'b1;
				line_start = 1'b0;
				return;
			end
			in_hdr = 1'b0;
		end
		// The LF of a CRLF pair closes nothing further.
		if (c == ChLf && was_cr) begin
			return;
		end
		if (c == ChCr || c == ChLf) begin
			saw_cr = (c == ChCr);
			close_record();
			return;
		end
		if (c == ChTab) begin
			line_start = 1'b0;
			if (field_idx < FieldMax) begin
				field_idx++;
			end
			char_idx = '0;
			return;
		end
		take_char(c);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Results are compared before the byte of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_parser();
			expected_snps.delete();
			open_snps <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_snps.size() == 0) begin
					mismatch_count++;
					$display("%0t: expected no record, got snp_id %0d alleles %02h %02h",
						$time, result.snp_id, result.allele_one, result.allele_two);
				end else begin
					head_snp = expected_snps.pop_front();
					check_field("snp_id", head_snp.snp_id, result.snp_id);
					check_field("allele_one", 32'(head_snp.allele_one),
						32'(result.allele_one));
					check_field("allele_two", 32'(head_snp.allele_two),
						32'(result.allele_two));
				end
			end
			if (stream.valid && stream.ready) begin
				parse_byte(stream.byte_in);
			end
			open_snps <= expected_snps.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, byte stream stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
	import grp_pkg::*;

	typedef enum logic [1:0] {EndLf, EndCr, EndCrLf, EndNone} line_end_t;

	localparam int QuietLimit = 2000;
	localparam int PhaseBytes = 380;

	logic clk;
	logic arst_n;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   sent_bytes = 0;
	int   quiet_cycles;
	int   fail_count;
	int   pending_snps;

	grp_byte_if stream_if ();
	grp_rec_if  rec_if ();

	genotype_record_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if.sink),
		.result (rec_if.source)
	);

	grp_record_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.result  (rec_if),
		.errors  (fail_count),
		.pending (pending_snps)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The record sink stalls at the rate of the current phase.
	always @(posedge clk) begin
		rec_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((stream_if.valid && stream_if.ready) || (rec_if.valid && rec_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one byte, with random idle cycles first, and waits until it is taken.
	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(0, 99) < idle_pct) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid   <= 1'b1;
		stream_if.byte_in <= c;
		do @(posedge clk); while (!stream_if.ready);
		sent_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	task automatic end_line(input line_end_t kind);
		case (kind)
			EndLf: send_byte(ChLf);
			EndCr: send_byte(ChCr);
			EndCrLf: begin
				send_byte(ChCr);
				send_byte(ChLf);
			end
			default: ;
		endcase
	endtask

	// Any byte other than NUL, tab, CR and LF, so it never ends a field or record.
	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == ChTab || c == ChCr || c == ChLf);
		return c;
	endfunction

	task automatic send_digits(input int count);
		repeat (count) send_byte(8'(Ch0 + $urandom_range(0, 9)));
	endtask

	// A record with random content; mostly well formed, sometimes short or long.
	task automatic send_record();
		int    roll;
		int    nfields;
		string bases;
		bases = "ACGT";
		roll = $urandom_range(0, 99);
		nfields = (roll < 80) ? 4 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(5, 7);
		case ($urandom_range(0, 9))
			0: send_byte(noise_char());
			1: send_byte("i");
			default: send_byte(ChR);
		endcase
		send_byte(($urandom_range(0, 3) == 0) ? noise_char() : "s");
		send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 7));
		if ($urandom_range(0, 4) == 0) begin
			send_byte(noise_char());
		end
		for (int f = 1; f < nfields; f++) begin
			send_byte(ChTab);
			case (f)
				1: begin
					roll = $urandom_range(0, 7);
					if (roll == 0) begin
						send_text("MT");
					end else if (roll == 1) begin
						send_byte(noise_char());
					end else begin
						send_digits($urandom_range(1, 2));
					end
				end
				2: send_digits($urandom_range(1, 9));
				3: begin
					repeat ($urandom_range(0, 3)) begin
						send_byte(($urandom_range(0, 3) == 0) ? noise_char()
							: bases[$urandom_range(0, 3)]);
					end
				end
				default: repeat ($urandom_range(0, 4)) send_byte(noise_char());
			endcase
		end
		end_line(line_end_t'($urandom_range(0, 2)));
	endtask

	initial begin
		int roll;
		arst_n            = 1'b0;
		stream_if.valid   = 1'b0;
		stream_if.byte_in = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed file: a header comment with a CR inside, then the corner records.
		send_text("#c");
		end_line(EndCr);
		send_text("x");
		end_line(EndLf);
		send_text("rs1\t1\t5\tAG");
		end_line(EndCrLf);
		send_text("rs2\tMT\t1\tCC");
		end_line(EndLf);
		send_text("rx7\t2\t3\tA");
		end_line(EndCr);
		send_text("rs8\t2\t3\t");
		end_line(EndLf);
		send_text("rs9\tX");
		end_line(EndLf);
		send_text("rs10\t1\t1\tTT\tx\ty");
		end_line(EndLf);
		send_text("r");
		end_line(EndLf);
		end_line(EndCrLf);
		send_text("#rs5\t1\t1\tGG");
		end_line(EndLf);
		send_text("rs12a3\t1\t1\tGT");
		end_line(EndLf);
		send_text("rs99999999999\t1\t1\tAC");
		end_line(EndLf);
		send_text("rs0\t1\t1\tAA");
		end_line(EndLf);
		// A zero byte closes the open record and starts a new file.
		send_text("rs4\t1\t1\tG");
		send_byte(ChNul);
		send_text("#h");
		end_line(EndLf);
		send_text("rs3\t1\t1\t");
		send_byte(8'hFF);
		send_byte(8'h80);
		end_line(EndCrLf);

		// Random phases with different idle and stall rates.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1) ? 60 : (phase == 3) ? 32 : 0;
			stall_pct = (phase == 2) ? 60 : (phase == 3) ? 32 : 0;
			roll = sent_bytes + PhaseBytes;
			while (sent_bytes < roll) begin
				case ($urandom_range(0, 99)) inside
					[0:74]: send_record();
					[75:82]: begin
						// New file with a few header comment lines.
						send_byte(ChNul);
						repeat ($urandom_range(0, 3)) begin
							send_byte(ChHash);
							repeat ($urandom_range(0, 6)) begin
								send_byte(($urandom_range(0, 5) == 0) ? ChCr : noise_char());
							end
							send_byte(ChLf);
						end
					end
					[83:92]: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
					default: end_line(line_end_t'($urandom_range(0, 2)));
				endcase
			end
		end
		stream_if.valid <= 1'b0;

		// Drain the records still on their way out.
		do @(posedge clk); while (pending_snps != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
